### hw/rtl/epsf_pkg.sv
`default_nettype none
package epsf_pkg;

  localparam int DefNumChannels = 2;
  localparam int DefFirTaps     = 8;
  localparam int DefCountWidth  = 16;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] RegCounterPeriod = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCountsPerRev  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGearRatio     = 2'd2;

  localparam logic [16:0] RstCounterPeriod = 17'd65536;
  localparam logic [15:0] RstCountsPerRev  = 16'd1024;
  localparam logic [9:0]  RstGearRatio     = 10'd1;

  // 60000 rpm per count per ms, times 256 for the Q24.8 result.
  localparam logic [23:0] RpmScale = 24'd15360000;

  localparam int TapIdxW = 5;

  typedef struct packed {
    logic               load;
    logic               pos_mul;
    logic               pos_upd;
    logic               den1;
    logic               den2;
    logic               num1;
    logic               num2;
    logic               num3;
    logic               div_init;
    logic               div_step;
    logic               sat_push;
    logic               mul_en;
    logic               acc_en;
    logic               fir_fin;
    logic               out_load;
    logic [TapIdxW-1:0] idx;
  } epsf_cmd_t;

  typedef struct packed {
    logic elapsed_zero;
  } epsf_sts_t;

  // Q0.16 filter taps; coefficient n weights the sample n steps old.
  function automatic logic signed [16:0] fir_coef(input logic [TapIdxW-1:0] n);
    logic signed [16:0] c;
    case (n)
      5'd1:    c = 17'sd2893;
      5'd2:    c = -17'sd7440;
      5'd3:    c = 17'sd11495;
      5'd4:    c = 17'sd52429;
      5'd5:    c = 17'sd11495;
      5'd6:    c = -17'sd7440;
      5'd7:    c = 17'sd2893;
      default: c = 17'sd0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/epsf_ctrl.sv
`default_nettype none
module epsf_ctrl
  import epsf_pkg::*;
#(
  parameter int FIR_TAPS = DefFirTaps
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  output logic           m_tvalid_o,
  input  wire logic      m_tready_i,
  input  wire epsf_sts_t sts_i,
  output epsf_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StPosMul, StPosAdd, StDen1, StDen2, StNum1, StNum2, StNum3,
    StDivInit, StDiv, StSat, StMac, StFin, StDone
  } state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  logic       out_valid_q;

  assign s_tready_o = (state_q == StIdle);
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.idx      = cnt_q[TapIdxW-1:0];
    cmd_o.load     = (state_q == StIdle) && s_tvalid_i;
    cmd_o.pos_mul  = (state_q == StPosMul);
    cmd_o.pos_upd  = (state_q == StPosAdd);
    cmd_o.den1     = (state_q == StDen1);
    cmd_o.den2     = (state_q == StDen2);
    cmd_o.num1     = (state_q == StNum1);
    cmd_o.num2     = (state_q == StNum2);
    cmd_o.num3     = (state_q == StNum3);
    cmd_o.div_init = (state_q == StDivInit);
    cmd_o.div_step = (state_q == StDiv);
    cmd_o.sat_push = (state_q == StSat);
    cmd_o.mul_en   = (state_q == StMac) && (cnt_q < 6'(FIR_TAPS));
    cmd_o.acc_en   = (state_q == StMac) && (cnt_q != 6'd0);
    cmd_o.fir_fin  = (state_q == StFin);
    cmd_o.out_load = (state_q == StDone) && (!out_valid_q || m_tready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (s_tvalid_i) begin
            state_q <= StPosMul;
          end
        end
        StPosMul: state_q <= StPosAdd;
        StPosAdd: state_q <= sts_i.elapsed_zero ? StDone : StDen1;
        StDen1:   state_q <= StDen2;
        StDen2:   state_q <= StNum1;
        StNum1:   state_q <= StNum2;
        StNum2:   state_q <= StNum3;
        StNum3:   state_q <= StDivInit;
        StDivInit: begin
          cnt_q   <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          if (cnt_q == 6'd31) begin
            state_q <= StSat;
          end
          cnt_q <= cnt_q + 6'd1;
        end
        StSat: begin
          cnt_q   <= '0;
          state_q <= StMac;
        end
        StMac: begin
          if (cnt_q == 6'(FIR_TAPS)) begin
            state_q <= StFin;
          end
          cnt_q <= cnt_q + 6'd1;
        end
        StFin: state_q <= StDone;
        StDone: begin
          if (!out_valid_q || m_tready_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || m_tready_i))
    else $error("result register overwritten while still pending");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> !s_tready_o)
    else $error("second request taken while one is in flight");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (cnt_q < 6'd32))
    else $error("divider step count out of range");

endmodule
`default_nettype wire

### hw/rtl/epsf_datapath.sv
`default_nettype none
module epsf_datapath
  import epsf_pkg::*;
#(
  parameter int NUM_CHANNELS = DefNumChannels,
  parameter int FIR_TAPS     = DefFirTaps,
  parameter int COUNT_WIDTH  = DefCountWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                in_channel_i,
  input  wire logic [15:0]         in_count_i,
  input  wire logic                in_wrapped_i,
  input  wire logic                in_counting_down_i,
  input  wire logic [15:0]         in_elapsed_ms_i,
  input  wire epsf_cmd_t           cmd_i,
  output epsf_sts_t                sts_o,
  output logic                     out_channel_o,
  output logic [47:0]              out_position_o,
  output logic [31:0]              out_speed_rpm_o,
  output logic                     out_speed_updated_o
);

  localparam int ChW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TapW   = (FIR_TAPS > 1) ? $clog2(FIR_TAPS) : 1;
  localparam int Depth  = NUM_CHANNELS * FIR_TAPS;
  localparam int HistW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int AccW   = 50 + $clog2(FIR_TAPS);

  logic [16:0] period_q;
  logic [15:0] cpr_q;
  logic [9:0]  gr_q;

  logic [31:0]        wrap_q [NUM_CHANNELS];
  logic [47:0]        prev_q [NUM_CHANNELS];
  logic signed [31:0] held_q [NUM_CHANNELS];
  logic signed [31:0] hist_q [Depth];

  logic [ChW-1:0] ch_q;
  logic           chin_q;
  logic [15:0]    cnt_q;
  logic [15:0]    elapsed_q;
  logic [47:0]    pmul_q;
  logic [47:0]    pos_q;
  logic           neg_q;
  logic [47:0]    mag_q;
  logic [31:0]    den_a_q;
  logic [41:0]    den_q;
  logic [47:0]    lo_p_q;
  logic [47:0]    hi_p_q;
  logic [71:0]    num_q;
  logic           big_q;
  logic [41:0]    rem_q;
  logic [31:0]    div_lo_q;
  logic [31:0]    quo_q;
  logic signed [48:0]     prod_q;
  logic signed [AccW-1:0] acc_q;

  logic [ChW-1:0]     ch_in;
  logic [15:0]        cnt_in;
  logic [15:0]        cpr_eff;
  logic [9:0]         gr_eff;
  logic signed [49:0] wrap_prod;
  logic [47:0]        pos_new;
  logic [47:0]        delta;
  logic [42:0]        div_t;
  logic               div_ge;
  logic [31:0]        q_sel;
  logic [31:0]        q_lim;
  logic [31:0]        q_clip;
  logic [31:0]        raw_spd;
  logic [HistW-1:0]   base_idx;
  logic [HistW-1:0]   rd_idx;
  logic signed [AccW-1:0] acc_rnd;
  logic signed [AccW-17:0] fir_y;
  logic signed [31:0] fir_sat;

  always_comb begin
    ch_in = '0;
    if (NUM_CHANNELS > 1) begin
      ch_in = ChW'(in_channel_i);
    end
    for (int i = 0; i < 16; i++) begin
      cnt_in[i] = in_count_i[i] & (i < COUNT_WIDTH);
    end
  end

  assign cpr_eff   = (cpr_q == '0) ? 16'd1 : cpr_q;
  assign gr_eff    = (gr_q == '0) ? 10'd1 : gr_q;
  assign wrap_prod = $signed(wrap_q[ch_q]) * $signed({1'b0, period_q});
  assign pos_new   = pmul_q + {32'd0, cnt_q};
  assign delta     = pos_new - prev_q[ch_q];

  assign div_t  = {rem_q, div_lo_q[31]};
  assign div_ge = (div_t >= {1'b0, den_q});

  assign q_sel   = big_q ? '1 : quo_q;
  assign q_lim   = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
  assign q_clip  = (q_sel > q_lim) ? q_lim : q_sel;
  assign raw_spd = neg_q ? (32'd0 - q_clip) : q_clip;

  assign base_idx = HistW'(ch_q * FIR_TAPS);
  assign rd_idx   = base_idx + HistW'(cmd_i.idx[TapW-1:0]);

  assign acc_rnd = acc_q + AccW'(32768);
  assign fir_y   = acc_rnd[AccW-1:16];
  always_comb begin
    if (fir_y > (AccW-16)'(32'sh7FFF_FFFF)) begin
      fir_sat = 32'sh7FFF_FFFF;
    end else if (fir_y < -(AccW-16)'(64'sh8000_0000)) begin
      fir_sat = 32'sh8000_0000;
    end else begin
      fir_sat = fir_y[31:0];
    end
  end

  assign sts_o.elapsed_zero = (elapsed_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= RstCounterPeriod;
      cpr_q    <= RstCountsPerRev;
      gr_q     <= RstGearRatio;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        wrap_q[c] <= '0;
        prev_q[c] <= '0;
        held_q[c] <= '0;
      end
      for (int e = 0; e < Depth; e++) begin
        hist_q[e] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegCounterPeriod: period_q <= cfg_data_i;
          RegCountsPerRev:  cpr_q    <= cfg_data_i[15:0];
          RegGearRatio:     gr_q     <= cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (cmd_i.load && in_wrapped_i) begin
        wrap_q[ch_in] <= in_counting_down_i ? (wrap_q[ch_in] - 32'd1)
                                            : (wrap_q[ch_in] + 32'd1);
      end
      if (cmd_i.pos_upd) begin
        prev_q[ch_q] <= pos_new;
      end
      if (cmd_i.sat_push) begin
        for (int e = 0; e < Depth; e++) begin
          if (HistW'(e) == base_idx) begin
            hist_q[e] <= raw_spd;
          end else if ((e > int'(base_idx)) && (e < int'(base_idx) + FIR_TAPS)) begin
            hist_q[e] <= hist_q[(e > 0) ? e - 1 : 0];
          end
        end
      end
      if (cmd_i.fir_fin) begin
        held_q[ch_q] <= fir_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ch_q      <= ch_in;
      chin_q    <= in_channel_i;
      cnt_q     <= cnt_in;
      elapsed_q <= in_elapsed_ms_i;
    end
    if (cmd_i.pos_mul) begin
      pmul_q <= wrap_prod[47:0];
    end
    if (cmd_i.pos_upd) begin
      pos_q <= pos_new;
      neg_q <= delta[47];
      mag_q <= delta[47] ? (48'd0 - delta) : delta;
    end
    if (cmd_i.den1) begin
      den_a_q <= elapsed_q * cpr_eff;
    end
    if (cmd_i.den2) begin
      den_q <= den_a_q * gr_eff;
    end
    if (cmd_i.num1) begin
      lo_p_q <= mag_q[23:0] * RpmScale;
    end
    if (cmd_i.num2) begin
      hi_p_q <= mag_q[47:24] * RpmScale;
    end
    if (cmd_i.num3) begin
      num_q <= {hi_p_q, 24'd0} + {24'd0, lo_p_q};
    end
    if (cmd_i.div_init) begin
      big_q    <= ({2'b00, num_q} >= {den_q, 32'd0});
      rem_q    <= {2'b00, num_q[71:32]};
      div_lo_q <= num_q[31:0];
      quo_q    <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q    <= div_ge ? 42'(div_t - {1'b0, den_q}) : div_t[41:0];
      div_lo_q <= {div_lo_q[30:0], 1'b0};
      quo_q    <= {quo_q[30:0], div_ge};
    end
    if (cmd_i.sat_push) begin
      acc_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= hist_q[rd_idx] * fir_coef(cmd_i.idx);
    end
    if (cmd_i.out_load) begin
      out_channel_o       <= chin_q;
      out_position_o      <= pos_q;
      out_speed_rpm_o     <= held_q[ch_q];
      out_speed_updated_o <= (elapsed_q != '0);
    end
  end

endmodule
`default_nettype wire

### hw/rtl/encoder_position_speed_fir.sv
// Two-channel encoder position and speed block. Each request on the slave
// side is one sample for one channel; the block extends the counter with a
// signed wrap count into a 48-bit position and, when the elapsed time is
// nonzero, computes speed in rpm (Q24.8), filters it with an 8-tap FIR per
// channel and returns one result. For a sample with nonzero elapsed time a
// 32-step restoring divider and a one-tap-per-cycle FIR multiply-accumulate
// take most of the processing; a sample with zero elapsed time skips the
// speed path and goes straight from the position update to the result. One
// sample is processed at a time; the result register lets the next sample
// start while a result still waits on the master side, and a stall there
// holds the next sample in its final state until that register is free.
`default_nettype none
module encoder_position_speed_fir
  import epsf_pkg::*;
#(
  parameter int NUM_CHANNELS = DefNumChannels,
  parameter int FIR_TAPS     = DefFirTaps,
  parameter int COUNT_WIDTH  = DefCountWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                s_tvalid_i,
  output logic                     s_tready_o,
  // count[15:0], wrapped[16], counting_down[17], elapsed_ms[33:18], zeros
  input  wire logic [39:0]         s_tdata_i,
  // channel
  input  wire logic                s_tuser_i,
  output logic                     m_tvalid_o,
  input  wire logic                m_tready_i,
  // position[47:0], speed_rpm[79:48], speed_updated[80], zeros
  output logic [87:0]              m_tdata_o,
  // out_channel
  output logic                     m_tuser_o
);

  epsf_cmd_t   cmd;
  epsf_sts_t   sts;
  logic [47:0] position;
  logic [31:0] speed_rpm;
  logic        speed_updated;

  epsf_ctrl #(
    .FIR_TAPS (FIR_TAPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  epsf_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .FIR_TAPS     (FIR_TAPS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .in_channel_i        (s_tuser_i),
    .in_count_i          (s_tdata_i[15:0]),
    .in_wrapped_i        (s_tdata_i[16]),
    .in_counting_down_i  (s_tdata_i[17]),
    .in_elapsed_ms_i     (s_tdata_i[33:18]),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .out_channel_o       (m_tuser_o),
    .out_position_o      (position),
    .out_speed_rpm_o     (speed_rpm),
    .out_speed_updated_o (speed_updated)
  );

  assign m_tdata_o = {7'd0, speed_updated, speed_rpm, position};

endmodule
`default_nettype wire

### tb/encoder_position_speed_fir_tb.sv
`default_nettype none
module encoder_position_speed_fir_tb
  import epsf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic        channel;
    logic [15:0] count;
    logic        wrapped;
    logic        counting_down;
    logic [15:0] elapsed_ms;
  } sample_t;

  typedef struct packed {
    logic               channel;
    logic signed [47:0] position;
    logic signed [31:0] speed_rpm;
    logic               speed_updated;
  } motion_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                s_tvalid_i;
  logic                s_tready_o;
  logic [39:0]         s_tdata_i;
  logic                s_tuser_i;
  logic                m_tvalid_o;
  logic                m_tready_i;
  logic [87:0]         m_tdata_o;
  logic                m_tuser_o;

  encoder_position_speed_fir dut (.*);

  // Predictor state.
  logic [16:0]        period_reg;
  logic [15:0]        cpr_reg;
  logic [9:0]         gear_reg;
  logic [31:0]        wraps      [2];
  logic [47:0]        last_pos   [2];
  logic signed [31:0] taps_hist  [2][8];
  logic signed [31:0] held       [2];

  motion_t motion_q[$];
  int      errors;
  int      results_seen;
  int      updates_seen;
  bit      quiet_mode;
  bit      hold_off;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("encoder_position_speed_fir_tb failed");
    $finish;
  end

  function automatic logic signed [31:0] coef_q16(input int n);
    case (n)
      1, 7:    return 32'sd2893;
      2, 6:    return -32'sd7440;
      3, 5:    return 32'sd11495;
      4:       return 32'sd52429;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] rpm_q8(input logic signed [47:0] delta,
                                                 input logic [63:0] den);
    logic [127:0] mag;
    logic [127:0] q;
    logic [127:0] lim;
    mag = delta < 0 ? 128'(-64'(delta)) : 128'(64'(delta));
    lim = delta < 0 ? 128'd2147483648 : 128'd2147483647;
    q = (mag * 128'd15360000) / 128'(den);
    if (q > lim) q = lim;
    return delta < 0 ? 32'(-q) : 32'(q);
  endfunction

  function automatic motion_t predict_motion(input sample_t s);
    motion_t            m;
    logic [63:0]        den;
    logic signed [47:0] delta;
    logic signed [31:0] raw;
    logic signed [63:0] acc;
    logic signed [63:0] y;
    int                 c;
    c = s.channel;
    if (s.wrapped) wraps[c] = s.counting_down ? wraps[c] - 1 : wraps[c] + 1;
    m.position = 48'(64'(s.count) + 64'($signed(wraps[c])) * 64'(period_reg));
    m.speed_updated = 1'b0;
    if (s.elapsed_ms != 0) begin
      den = 64'(s.elapsed_ms) * 64'(cpr_reg == 0 ? 16'd1 : cpr_reg)
          * 64'(gear_reg == 0 ? 10'd1 : gear_reg);
      delta = m.position - last_pos[c];
      raw = rpm_q8(delta, den);
      for (int n = 7; n > 0; n--) taps_hist[c][n] = taps_hist[c][n-1];
      taps_hist[c][0] = raw;
      acc = 0;
      for (int n = 0; n < 8; n++) acc += 64'(taps_hist[c][n]) * 64'(coef_q16(n));
      y = (acc + 64'sd32768) >>> 16;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      held[c] = 32'(y);
      m.speed_updated = 1'b1;
    end
    m.speed_rpm = held[c];
    last_pos[c] = m.position;
    m.channel = s.channel;
    return m;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      RegCounterPeriod: period_reg = val;
      RegCountsPerRev:  cpr_reg = val[15:0];
      RegGearRatio:     gear_reg = val[9:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic send_sample(input sample_t s, input bit check_fixed, input motion_t fixed);
    motion_t m;
    if (!quiet_mode && $urandom_range(0, 5) == 0) begin
      s_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= s.channel;
    s_tdata_i  <= {6'd0, s.elapsed_ms, s.counting_down, s.wrapped, s.count};
    do @(posedge clk_i); while (!s_tready_o);
    m = predict_motion(s);
    if (check_fixed && m != fixed) begin
      $error("directed row prediction mismatch exp %h got %h", fixed, m);
      errors++;
    end
    motion_q.push_back(m);
  endtask

  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic sample_t rand_sample(input bit tiny);
    sample_t s;
    s = sample_t'(35'({$urandom, $urandom}));
    if ($urandom_range(0, 3) != 0) s.wrapped = 1'b0;
    if ($urandom_range(0, 7) == 0) s.elapsed_ms = 0;
    else if (tiny) s.elapsed_ms = $urandom_range(1, 50);
    return s;
  endfunction

  always @(posedge clk_i) begin
    motion_t exp_m;
    if (m_tvalid_o && m_tready_i) begin
      results_seen++;
      if (motion_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
      end else begin
        exp_m = motion_q.pop_front();
        updates_seen += exp_m.speed_updated;
        if (m_tuser_o !== exp_m.channel) begin
          $error("out_channel exp %0d got %0d", exp_m.channel, m_tuser_o);
          errors++;
        end
        if (m_tdata_o[47:0] !== exp_m.position) begin
          $error("position exp %0d got %0d", exp_m.position, $signed(m_tdata_o[47:0]));
          errors++;
        end
        if (m_tdata_o[79:48] !== exp_m.speed_rpm) begin
          $error("speed_rpm exp %0d got %0d", exp_m.speed_rpm, $signed(m_tdata_o[79:48]));
          errors++;
        end
        if (m_tdata_o[80] !== exp_m.speed_updated) begin
          $error("speed_updated exp %0d got %0d", exp_m.speed_updated, m_tdata_o[80]);
          errors++;
        end
      end
    end
  end

  initial begin
    m_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_tready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 4) == 0) begin
        m_tready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
    end
  end

  typedef struct {
    sample_t s;
    bit      fixed_ok;
    motion_t fixed;
  } row_t;

  row_t rows[$];

  initial begin
    sample_t s;
    errors = 0; results_seen = 0; updates_seen = 0;
    quiet_mode = 1'b0; hold_off = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i <= 1'b0; cfg_idx_i <= '0; cfg_data_i <= '0;
    s_tvalid_i <= 1'b0; s_tdata_i <= '0; s_tuser_i <= 1'b0;
    period_reg = RstCounterPeriod; cpr_reg = RstCountsPerRev; gear_reg = RstGearRatio;
    for (int c = 0; c < 2; c++) begin
      wraps[c] = 0; last_pos[c] = 0; held[c] = 0;
      for (int n = 0; n < 8; n++) taps_hist[c][n] = 0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    rows.push_back('{'{0, 16'd0, 0, 0, 16'd0}, 1, '{0, 48'sd0, 32'sd0, 1'b0}});
    rows.push_back('{'{1, 16'd0, 0, 0, 16'd1}, 1, '{1, 48'sd0, 32'sd0, 1'b1}});
    rows.push_back('{'{0, 16'hFFFF, 0, 0, 16'd0}, 1, '{0, 48'sd65535, 32'sd0, 1'b0}});
    rows.push_back('{'{0, 16'd0, 1, 0, 16'd0}, 1, '{0, 48'sd65536, 32'sd0, 1'b0}});
    rows.push_back('{'{0, 16'd0, 1, 1, 16'd0}, 1, '{0, 48'sd0, 32'sd0, 1'b0}});
    rows.push_back('{'{0, 16'd0, 1, 1, 16'd0}, 1, '{0, -48'sd65536, 32'sd0, 1'b0}});
    rows.push_back('{'{0, 16'hFFFF, 1, 0, 16'd1}, 0, '0});
    rows.push_back('{'{0, 16'h0000, 1, 1, 16'hFFFF}, 0, '0});
    rows.push_back('{'{1, 16'hFFFF, 1, 0, 16'd1}, 0, '0});
    rows.push_back('{'{1, 16'h1234, 0, 0, 16'd0}, 0, '0});
    rows.push_back('{'{1, 16'h0000, 1, 1, 16'd1}, 0, '0});
    for (int i = 0; i < 10; i++) rows.push_back('{'{i[0], 16'(i * 997), 0, 0, 16'd3}, 0, '0});
    foreach (rows[i]) send_sample(rows[i].s, rows[i].fixed_ok, rows[i].fixed);
    drain();

    // Extreme settings, zero divisors and an out-of-range index.
    write_reg(RegCounterPeriod, 17'd1);
    write_reg(RegCountsPerRev, 17'd0);
    write_reg(RegGearRatio, 17'd0);
    write_reg(2'd3, 17'h1FFFF);
    for (int i = 0; i < 12; i++) send_sample(rand_sample(1), 0, '0);
    hold_off = 1'b1;
    for (int i = 0; i < 8; i++) send_sample(rand_sample(0), 0, '0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(RegCounterPeriod, 17'd65536);
          write_reg(RegCountsPerRev, 17'd65535);
          write_reg(RegGearRatio, 17'd1023);
        end
        1: begin
          write_reg(RegCounterPeriod, 17'h1FFFF);
          write_reg(RegCountsPerRev, 17'd1);
          write_reg(RegGearRatio, 17'd1);
        end
        default: begin
          write_reg(RegCounterPeriod, 17'($urandom_range(1, 131071)));
          write_reg(RegCountsPerRev, 17'($urandom_range(0, 65535)));
          write_reg(RegGearRatio, 17'($urandom_range(0, 1023)));
        end
      endcase
      if (ph == 5) quiet_mode = 1'b1;
      for (int i = 0; i < 155; i++) send_sample(rand_sample($urandom_range(0, 1)), 0, '0);
      drain();
    end

    $display("Covered %0d results (%0d speed updates) over several register settings,",
             results_seen, updates_seen);
    $display("including wraps both ways, zero elapsed time and a long output stall.");
    if (errors == 0 && motion_q.size() == 0) begin
      $display("encoder_position_speed_fir_tb passed");
    end else begin
      $display("encoder_position_speed_fir_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
